/* rtl/sibq_pkg.sv */
// Shared constants, types and helper functions of the scanline split and IRQ bank queue.
package sibq_pkg;

    localparam int QUEUE_DEPTH       = 32;
    localparam int LAST_VISIBLE_LINE = 240;
    localparam int QW                = $clog2(QUEUE_DEPTH);
    localparam int IW                = $clog2(QUEUE_DEPTH + 1);
    localparam int NUM_BANKS         = 8;

    localparam logic [7:0] COUNT_TRIP   = 8'd254;
    localparam logic [7:0] COUNT_RELOAD = 8'd255;

    localparam logic [15:0] ADDR_MIRROR     = 16'hff01;
    localparam logic [15:0] ADDR_COUNT      = 16'hff02;
    localparam logic [15:0] ADDR_COUNT_HIGH = 16'hff06;
    localparam logic [15:0] ADDR_QUEUE_CLR  = 16'hff12;
    localparam logic [15:0] ADDR_SPLIT_Q    = 16'hff0a;
    localparam logic [15:0] ADDR_PAIR_Q     = 16'hff1a;
    localparam logic [15:0] ADDR_RELOAD     = 16'hff22;
    localparam logic [15:0] ADDR_PAIR_0     = 16'hff03;
    localparam logic [15:0] ADDR_PAIR_1     = 16'hff0b;
    localparam logic [15:0] ADDR_PAIR_2     = 16'hff13;
    localparam logic [15:0] ADDR_PAIR_3     = 16'hff1b;
    localparam logic [7:0]  SLOT_FIRST      = 8'h23;
    localparam logic [7:0]  SLOT_LAST       = 8'h5b;
    localparam logic [7:0]  IO_PAGE         = 8'hff;

    typedef logic [4:0] bank_t;

    typedef struct packed {
        logic                      irq;
        logic                      split_on;
        logic                      irq_en;
        logic [1:0]                mirror;
        logic [7:0]                counter;
        logic [IW-1:0]             split_cnt;
        logic [IW-1:0]             pair_cnt;
        logic [IW-1:0]             read_idx;
        bank_t [NUM_BANKS-1:0]     banks;
    } state_t;

    typedef struct packed {
        logic          split_we;
        logic          pair_we;
        logic [QW-1:0] addr;
        logic [7:0]    data;
    } qwr_t;

    typedef struct packed {
        logic [7:0] split_head;
        logic [7:0] pair_head;
        logic [7:0] split_rd;
        logic [7:0] pair_rd;
    } qrd_t;

    function automatic state_t reset_state();
        state_t s;
        s = '0;
        s.mirror = 2'd2;
        for (int i = 0; i < NUM_BANKS; i++)
        begin
            s.banks[i] = bank_t'(i);
        end
        return s;
    endfunction

    function automatic logic irq_hit(state_t s);
        return (s.counter == COUNT_TRIP) && s.irq_en
            && !(s.split_on && (s.read_idx != s.split_cnt));
    endfunction

endpackage

/* rtl/scanline_split_irq_bank_queue_core.sv */
// Top level of the scanline split and IRQ bank queue: input register, state and result register.
// The block takes one bus write or sync tick per clock cycle unless item_stall is high. An
// accepted item is held in the input register, its effect is worked out there and lands in
// the state and result registers when the output advances, and the sustained rate is one
// item per cycle while results are taken. The result shown is the full controller state after
// the item: IRQ level, mirroring mode and the eight pattern banks. Both queues are flip-flop
// arrays cleared by reset, so the block is ready at once.
module scanline_split_irq_bank_queue_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic        mode,
    input  logic [15:0] address,
    input  logic [7:0]  data,
    input  logic [8:0]  line,
    output logic        result_valid,
    input  logic        result_stall,
    output logic        irq,
    output logic [1:0]  mirror_mode,
    output logic [4:0]  bank_0,
    output logic [4:0]  bank_1,
    output logic [4:0]  bank_2,
    output logic [4:0]  bank_3,
    output logic [4:0]  bank_4,
    output logic [4:0]  bank_5,
    output logic [4:0]  bank_6,
    output logic [4:0]  bank_7
);

    logic                       in_valid_reg;
    logic                       mode_reg;
    logic [15:0]                address_reg;
    logic [7:0]                 data_reg;
    logic [8:0]                 line_reg;
    logic                       result_valid_reg;
    sibq_pkg::state_t           st_reg;
    sibq_pkg::state_t           st_next;
    sibq_pkg::qwr_t             qwr;
    sibq_pkg::qwr_t             qwr_gated;
    sibq_pkg::qrd_t             qrd;
    logic [sibq_pkg::QW-1:0]    rd_addr;
    logic                       advance;
    logic                       accept;
    logic                       commit;

    assign advance    = !result_valid_reg || !result_stall;
    assign item_stall = in_valid_reg && !advance;
    assign accept     = item_valid && !item_stall;
    assign commit     = in_valid_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            st_reg           <= sibq_pkg::reset_state();
        end
        else
        begin
            if (accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                result_valid_reg <= in_valid_reg;
            end
            if (commit)
            begin
                st_reg <= st_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg    <= mode;
            address_reg <= address;
            data_reg    <= data;
            line_reg    <= line;
        end
    end

    sibq_step u_step (
        .st      (st_reg),
        .mode    (mode_reg),
        .address (address_reg),
        .data    (data_reg),
        .line    (line_reg),
        .qrd     (qrd),
        .rd_addr (rd_addr),
        .qwr     (qwr),
        .st_next (st_next)
    );

    always_comb
    begin
        qwr_gated          = qwr;
        qwr_gated.split_we = qwr.split_we && commit;
        qwr_gated.pair_we  = qwr.pair_we && commit;
    end

    sibq_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (qwr_gated),
        .rd_addr (rd_addr),
        .rd      (qrd)
    );

    assign result_valid = result_valid_reg;
    assign irq          = st_reg.irq;
    assign mirror_mode  = st_reg.mirror;
    assign bank_0       = st_reg.banks[0];
    assign bank_1       = st_reg.banks[1];
    assign bank_2       = st_reg.banks[2];
    assign bank_3       = st_reg.banks[3];
    assign bank_4       = st_reg.banks[4];
    assign bank_5       = st_reg.banks[5];
    assign bank_6       = st_reg.banks[6];
    assign bank_7       = st_reg.banks[7];

endmodule

/* rtl/sibq_queue.sv */
// Split count and bank pair queues held in flip-flops, with one write port and read taps.
module sibq_queue (
    input  logic                             clk,
    input  logic                             rst_n,
    input  sibq_pkg::qwr_t                   wr,
    input  logic [sibq_pkg::QW-1:0]          rd_addr,
    output sibq_pkg::qrd_t                   rd
);

    logic [7:0] split_q_reg [sibq_pkg::QUEUE_DEPTH];
    logic [7:0] pair_q_reg  [sibq_pkg::QUEUE_DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < sibq_pkg::QUEUE_DEPTH; i++)
            begin
                split_q_reg[i] <= 8'd0;
                pair_q_reg[i]  <= 8'd0;
            end
        end
        else
        begin
            if (wr.split_we)
            begin
                split_q_reg[wr.addr] <= wr.data;
            end
            if (wr.pair_we)
            begin
                pair_q_reg[wr.addr] <= wr.data;
            end
        end
    end

    always_comb
    begin
        rd.split_head = split_q_reg[0];
        rd.pair_head  = pair_q_reg[0];
        rd.split_rd   = split_q_reg[rd_addr];
        rd.pair_rd    = pair_q_reg[rd_addr];
    end

endmodule

/* rtl/sibq_step.sv */
// Next-state logic for one bus write or sync tick.
module sibq_step (
    input  sibq_pkg::state_t                 st,
    input  logic                             mode,
    input  logic [15:0]                      address,
    input  logic [7:0]                       data,
    input  logic [8:0]                       line,
    input  sibq_pkg::qrd_t                   qrd,
    output logic [sibq_pkg::QW-1:0]          rd_addr,
    output sibq_pkg::qwr_t                   qwr,
    output sibq_pkg::state_t                 st_next
);

    function automatic sibq_pkg::state_t reload(sibq_pkg::state_t s, logic [7:0] cnt,
                                                logic [7:0] pair);
        sibq_pkg::state_t r;
        r = s;
        r.counter  = cnt;
        r.banks[0] = {pair[3:0], 1'b0};
        r.banks[1] = {pair[3:0], 1'b1};
        r.banks[2] = {pair[7:4], 1'b0};
        r.banks[3] = {pair[7:4], 1'b1};
        r.read_idx = r.read_idx + sibq_pkg::IW'(1);
        return r;
    endfunction

    logic             line0;
    logic [7:0]       slot_off;
    sibq_pkg::state_t s;

    assign line0    = mode && (line == 9'd0) && st.split_on;
    assign rd_addr  = line0 ? sibq_pkg::QW'(1) : st.read_idx[sibq_pkg::QW-1:0];
    assign slot_off = address[7:0] - sibq_pkg::SLOT_FIRST;

    always_comb
    begin
        s       = st;
        qwr     = '0;
        qwr.data = data;
        if (mode)
        begin
            if (line0)
            begin
                s.read_idx = '0;
                s = reload(s, qrd.split_head, qrd.pair_head);
            end
            if (line < 9'(sibq_pkg::LAST_VISIBLE_LINE))
            begin
                s.irq = sibq_pkg::irq_hit(s);
                if (s.counter == sibq_pkg::COUNT_RELOAD)
                begin
                    if ((s.read_idx != s.split_cnt)
                        && (s.read_idx < sibq_pkg::IW'(sibq_pkg::QUEUE_DEPTH)))
                    begin
                        s = reload(s, qrd.split_rd, qrd.pair_rd);
                    end
                end
                else if (s.split_on || s.irq_en)
                begin
                    s.counter = s.counter + 8'd1;
                end
            end
        end
        else
        begin
            unique case (address)
                sibq_pkg::ADDR_MIRROR:
                begin
                    s.mirror   = {~data[1], data[0]};
                    s.split_on = data[6];
                    s.irq_en   = data[2];
                    s.irq      = sibq_pkg::irq_hit(s);
                end
                sibq_pkg::ADDR_COUNT:
                begin
                    s.counter = data;
                end
                sibq_pkg::ADDR_COUNT_HIGH:
                begin
                    s.counter = {data[3:0], s.counter[3:0]};
                end
                sibq_pkg::ADDR_QUEUE_CLR:
                begin
                    if (!s.irq_en)
                    begin
                        s.split_cnt = '0;
                        s.pair_cnt  = '0;
                        if (s.split_on)
                        begin
                            s.read_idx = '0;
                        end
                    end
                    s.irq = sibq_pkg::irq_hit(s);
                end
                sibq_pkg::ADDR_SPLIT_Q:
                begin
                    if (s.split_cnt < sibq_pkg::IW'(sibq_pkg::QUEUE_DEPTH))
                    begin
                        qwr.split_we = 1'b1;
                        qwr.addr     = s.split_cnt[sibq_pkg::QW-1:0];
                        if (!s.irq_en)
                        begin
                            s.split_cnt = s.split_cnt + sibq_pkg::IW'(1);
                        end
                    end
                    if (s.irq_en)
                    begin
                        s.split_cnt = '0;
                    end
                    s.irq = sibq_pkg::irq_hit(s);
                end
                sibq_pkg::ADDR_PAIR_Q:
                begin
                    if (s.pair_cnt < sibq_pkg::IW'(sibq_pkg::QUEUE_DEPTH))
                    begin
                        qwr.pair_we = 1'b1;
                        qwr.addr    = s.pair_cnt[sibq_pkg::QW-1:0];
                        if (!s.irq_en)
                        begin
                            s.pair_cnt = s.pair_cnt + sibq_pkg::IW'(1);
                        end
                    end
                    if (s.irq_en)
                    begin
                        s.pair_cnt = '0;
                    end
                    s.irq = sibq_pkg::irq_hit(s);
                end
                sibq_pkg::ADDR_RELOAD:
                begin
                    if (s.split_on)
                    begin
                        if (!s.irq_en)
                        begin
                            s.read_idx = '0;
                            s.counter  = 8'd0;
                            s = reload(s, qrd.split_head, qrd.pair_head);
                        end
                        else if (s.read_idx < sibq_pkg::IW'(sibq_pkg::QUEUE_DEPTH))
                        begin
                            s = reload(s, qrd.split_rd, qrd.pair_rd);
                        end
                    end
                    s.irq = sibq_pkg::irq_hit(s);
                end
                sibq_pkg::ADDR_PAIR_0, sibq_pkg::ADDR_PAIR_1,
                sibq_pkg::ADDR_PAIR_2, sibq_pkg::ADDR_PAIR_3:
                begin
                    s.banks[{address[4:3], 1'b0}] = {data[3:0], 1'b0};
                    s.banks[{address[4:3], 1'b1}] = {data[3:0], 1'b1};
                end
                default:
                begin
                    if ((address[15:8] == sibq_pkg::IO_PAGE)
                        && (address[7:0] >= sibq_pkg::SLOT_FIRST)
                        && (address[7:0] <= sibq_pkg::SLOT_LAST)
                        && (slot_off[2:0] == 3'd0))
                    begin
                        s.banks[slot_off[5:3]] = data[4:0];
                    end
                end
            endcase
        end
        st_next = s;
    end

endmodule

/* rtl/sibq_checker.sv */
// Port-level checks of the scanline split and IRQ bank queue, bound to the top level.
module sibq_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        item_valid,
    input logic        item_stall,
    input logic        mode,
    input logic [15:0] address,
    input logic [7:0]  data,
    input logic        result_valid,
    input logic        result_stall,
    input logic        irq,
    input logic [1:0]  mirror_mode,
    input logic [4:0]  bank_0,
    input logic [4:0]  bank_1,
    input logic [4:0]  bank_2,
    input logic [4:0]  bank_3,
    input logic [4:0]  bank_4,
    input logic [4:0]  bank_5,
    input logic [4:0]  bank_6,
    input logic [4:0]  bank_7
);

    logic in_xfer;
    logic mirror_wr;

    assign in_xfer   = item_valid && !item_stall;
    assign mirror_wr = in_xfer && !mode && (address == sibq_pkg::ADDR_MIRROR);

    // The input side only stalls when a finished result is waiting and is itself stalled.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (result_valid && result_stall))
        else $error("input stalled without a stalled result");

    // A result that appears on an empty output comes from a matching earlier input transfer.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(in_xfer, 2))
        else $error("result appeared without a matching input transfer");

    // A mirroring write that disables the IRQ leaves the IRQ low and sets the mirror mode.
    a_mirror_write: assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(result_valid) && $past(mirror_wr, 2))
        |-> (!irq || $past(data[2], 2))
            && (mirror_mode[1] == !$past(data[1], 2))
            && (mirror_mode[0] == $past(data[0], 2)))
        else $error("mirroring write gave a wrong result");

    // A stalled result holds its payload.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> (result_valid && $stable(irq)
            && $stable(mirror_mode) && $stable(bank_0) && $stable(bank_1)
            && $stable(bank_2) && $stable(bank_3) && $stable(bank_4)
            && $stable(bank_5) && $stable(bank_6) && $stable(bank_7)))
        else $error("stalled result changed");

endmodule

bind scanline_split_irq_bank_queue_core sibq_checker u_sibq_checker (.*);
